// ----- rtl/rmc_pkg.sv -----
// ----------------------------------------------------------------------------
// rmc_pkg: shared types and constants of the rmc sentence parser
// Field widths, character codes, the result side-data struct and a
// power-of-ten table for fraction digit weights.
// ----------------------------------------------------------------------------
package rmc_pkg;

    localparam int SENTENCE_MAX_DEF    = 128;
    localparam int FRACTION_DIGITS_DEF = 5;

    localparam int ID_W    = 40;
    localparam int UTC_W   = 7;
    localparam int CHR_W   = 8;
    localparam int E4_W    = 20;
    localparam int DEG_W   = 10;
    localparam int MIN_W   = 7;
    localparam int FHI_W   = 14;
    localparam int DE6_W   = 30;
    localparam int MAG_W   = 31;
    localparam int LATD_W  = 28;
    localparam int TDATA_W = 192;

    localparam int MICRO    = 1000000;
    localparam int E4_SCALE = 10000;

    localparam logic [CHR_W-1:0] CH_ZERO  = 8'h30;
    localparam logic [CHR_W-1:0] CH_NINE  = 8'h39;
    localparam logic [CHR_W-1:0] CH_COMMA = 8'h2C;
    localparam logic [CHR_W-1:0] CH_DOT   = 8'h2E;
    localparam logic [CHR_W-1:0] CH_SOUTH = 8'h53;
    localparam logic [CHR_W-1:0] CH_WEST  = 8'h57;

    // everything of a sentence result except the coordinate values
    typedef struct packed {
        logic [CHR_W-1:0]           lon_h;
        logic [CHR_W-1:0]           lat_h;
        logic [CHR_W-1:0]           status;
        logic [3:0][UTC_W-1:0]      utc;     // hour in [0] up to hundredths in [3]
        logic [ID_W-1:0]            id;
    } rmc_side_t;

    function automatic logic [23:0] pow10(input logic [2:0] e);
        logic [23:0] v;
        case (e)
            3'd0:    v = 24'd1;
            3'd1:    v = 24'd10;
            3'd2:    v = 24'd100;
            3'd3:    v = 24'd1000;
            3'd4:    v = 24'd10000;
            3'd5:    v = 24'd100000;
            3'd6:    v = 24'd1000000;
            default: v = 24'd10000000;
        endcase
        return v;
    endfunction

endpackage

// ----- rtl/nmea_rmc_sentence_parser_core.sv -----
// ----------------------------------------------------------------------------
// nmea_rmc_sentence_parser_core: rmc sentence parser, one character per cycle
// The result item passes the snapshot register and four conversion stages
// after the edge that takes the character flagged last. Throughput: one
// character per cycle unless the output stalls; back-to-back sentences are fine.
// Reset: asynchronous, active low; clears parser state and all stage valids.
// ----------------------------------------------------------------------------
module nmea_rmc_sentence_parser_core
    import rmc_pkg::*;
#(
    parameter int SENTENCE_MAX    = SENTENCE_MAX_DEF,
    parameter int FRACTION_DIGITS = FRACTION_DIGITS_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               s_axis_tvalid,
    output logic               s_axis_tready,
    input  logic [7:0]         s_axis_tdata,   // char_in
    input  logic               s_axis_tlast,   // last_char
    output logic               m_axis_tvalid,
    input  logic               m_axis_tready,
    // sentence_id, utc_hour, utc_minute, utc_second, utc_hundredths, status_char,
    // lat_minutes_e4, lat_microdeg, lon_minutes_e4, lon_microdeg, lat_hemisphere,
    // lon_hemisphere, one zero pad bit
    output logic [TDATA_W-1:0] m_axis_tdata
);

    localparam int FRAC_W = $clog2(10**FRACTION_DIGITS);

    logic               take;
    logic [4:0]         v_reg;
    logic [5:0]         rdy;

    rmc_side_t          snap_side;
    rmc_side_t          side_reg [1:4];

    logic [DEG_W-1:0]   lat_deg, lon_deg;
    logic [MIN_W-1:0]   lat_min, lon_min;
    logic [FRAC_W-1:0]  lat_frac, lon_frac;
    logic [FHI_W-1:0]   lat_frac_hi, lon_frac_hi;
    logic [E4_W-1:0]    lat_e4, lon_e4;
    logic [MAG_W-1:0]   lat_mag, lon_mag;

    // a stage takes new data when it is empty or its contents move on
    always_comb
    begin
        rdy[5] = m_axis_tready;
        for (int k = 4; k >= 0; k--)
            rdy[k] = !v_reg[k] || rdy[k+1];
    end

    assign s_axis_tready = rdy[0];
    assign take          = s_axis_tvalid && rdy[0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else
        begin
            if (rdy[0])
                v_reg[0] <= take && s_axis_tlast;
            for (int k = 1; k <= 4; k++)
            begin
                if (rdy[k])
                    v_reg[k] <= v_reg[k-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy[1])
            side_reg[1] <= snap_side;
        for (int k = 2; k <= 4; k++)
        begin
            if (rdy[k])
                side_reg[k] <= side_reg[k-1];
        end
    end

    rmc_char_parser #(
        .SENTENCE_MAX    (SENTENCE_MAX),
        .FRACTION_DIGITS (FRACTION_DIGITS)
    ) u_parser (
        .clk         (clk),
        .rst_n       (rst_n),
        .take        (take),
        .char_in     (s_axis_tdata),
        .last_char   (s_axis_tlast),
        .snap_side   (snap_side),
        .lat_deg     (lat_deg),
        .lat_min     (lat_min),
        .lat_frac    (lat_frac),
        .lat_frac_hi (lat_frac_hi),
        .lon_deg     (lon_deg),
        .lon_min     (lon_min),
        .lon_frac    (lon_frac),
        .lon_frac_hi (lon_frac_hi)
    );

    rmc_coord_conv #(
        .FRACTION_DIGITS (FRACTION_DIGITS)
    ) u_lat_conv (
        .clk     (clk),
        .ce      (rdy[4:1]),
        .deg     (lat_deg),
        .mi      (lat_min),
        .frac    (lat_frac),
        .frac_hi (lat_frac_hi),
        .neg     (snap_side.lat_h == CH_SOUTH),
        .e4      (lat_e4),
        .mag     (lat_mag)
    );

    rmc_coord_conv #(
        .FRACTION_DIGITS (FRACTION_DIGITS)
    ) u_lon_conv (
        .clk     (clk),
        .ce      (rdy[4:1]),
        .deg     (lon_deg),
        .mi      (lon_min),
        .frac    (lon_frac),
        .frac_hi (lon_frac_hi),
        .neg     (snap_side.lon_h == CH_WEST),
        .e4      (lon_e4),
        .mag     (lon_mag)
    );

    assign m_axis_tvalid = v_reg[4];
    assign m_axis_tdata  = {1'b0,
                            side_reg[4].lon_h,
                            side_reg[4].lat_h,
                            lon_mag,
                            lon_e4,
                            lat_mag[LATD_W-1:0],
                            lat_e4,
                            side_reg[4].status,
                            side_reg[4].utc,
                            side_reg[4].id};

endmodule

// ----- rtl/rmc_char_parser.sv -----
// ----------------------------------------------------------------------------
// rmc_char_parser: per-character field splitter and digit accumulator
// Tracks field, position and parse phase, accumulates time and coordinate
// digits, and snapshots the raw sentence values on the last character.
// ----------------------------------------------------------------------------
module rmc_char_parser
    import rmc_pkg::*;
#(
    parameter int SENTENCE_MAX    = SENTENCE_MAX_DEF,
    parameter int FRACTION_DIGITS = FRACTION_DIGITS_DEF
)
(
    input  logic                                         clk,
    input  logic                                         rst_n,
    input  logic                                         take,
    input  logic [CHR_W-1:0]                             char_in,
    input  logic                                         last_char,
    output rmc_side_t                                    snap_side,
    output logic [DEG_W-1:0]                             lat_deg,
    output logic [MIN_W-1:0]                             lat_min,
    output logic [$clog2(10**FRACTION_DIGITS)-1:0]       lat_frac,
    output logic [FHI_W-1:0]                             lat_frac_hi,
    output logic [DEG_W-1:0]                             lon_deg,
    output logic [MIN_W-1:0]                             lon_min,
    output logic [$clog2(10**FRACTION_DIGITS)-1:0]       lon_frac,
    output logic [FHI_W-1:0]                             lon_frac_hi
);

    localparam int FRAC_W = $clog2(10**FRACTION_DIGITS);
    localparam int CP_W   = $clog2(SENTENCE_MAX + 1);

    localparam logic [3:0] FLD_TIME   = 4'd1;
    localparam logic [3:0] FLD_STATUS = 4'd2;
    localparam logic [3:0] FLD_LAT    = 4'd3;
    localparam logic [3:0] FLD_NS     = 4'd4;
    localparam logic [3:0] FLD_LON    = 4'd5;
    localparam logic [3:0] FLD_EW     = 4'd6;
    localparam logic [3:0] FLD_MAX    = 4'd15;

    // time field phases
    localparam logic [2:0] PH_T_HH   = 3'd0;
    localparam logic [2:0] PH_T_SS   = 3'd2;
    localparam logic [2:0] PH_T_DOT  = 3'd3;
    localparam logic [2:0] PH_T_HS   = 3'd4;
    localparam logic [2:0] PH_T_DONE = 3'd5;
    // coordinate field phases
    localparam logic [2:0] PH_C_DEG  = 3'd0;
    localparam logic [2:0] PH_C_MIN  = 3'd1;
    localparam logic [2:0] PH_C_FRAC = 3'd2;
    localparam logic [2:0] PH_C_DONE = 3'd3;

    typedef struct packed {
        logic [DEG_W-1:0]  deg;
        logic [MIN_W-1:0]  mi;
        logic [FRAC_W-1:0] frac;
        logic [FHI_W-1:0]  frac_hi;
    } coord_t;

    logic [3:0]            fn_reg, fn_next;
    logic [CP_W-1:0]       cp_reg, cp_next;
    logic [2:0]            dp_reg, dp_next;
    logic [2:0]            ph_reg, ph_next;
    logic                  fs_reg, fs_next;
    logic [ID_W-1:0]       id_reg, id_next;
    logic [3:0][UTC_W-1:0] tp_reg, tp_next;
    coord_t                acc_reg, acc_next;
    logic [2:0]            cnt_reg, cnt_next;
    coord_t                lat_reg, lat_next;
    coord_t                lon_reg, lon_next;
    logic [2:0][CHR_W-1:0] ch_reg, ch_next;

    rmc_side_t             snap_side_reg;
    coord_t                snap_lat_reg, snap_lon_reg;

    logic                  is_dig;
    logic [3:0]            dval;
    logic [1:0]            part;
    logic [2:0]            grp_next;
    logic [2:0]            ndeg;
    logic [9:0]            mi_wide;
    logic                  fin;

    always_comb
    begin
        fn_next  = fn_reg;
        cp_next  = cp_reg;
        dp_next  = dp_reg;
        ph_next  = ph_reg;
        fs_next  = fs_reg;
        id_next  = id_reg;
        tp_next  = tp_reg;
        acc_next = acc_reg;
        cnt_next = cnt_reg;
        lat_next = lat_reg;
        lon_next = lon_reg;
        ch_next  = ch_reg;

        is_dig   = char_in inside {[CH_ZERO:CH_NINE]};
        dval     = 4'(char_in - CH_ZERO);
        part     = (ph_reg == PH_T_HS) ? 2'd3 : ph_reg[1:0];
        grp_next = (ph_reg == PH_T_HS) ? PH_T_DONE : ph_reg + 3'd1;
        ndeg     = (fn_reg == FLD_LAT) ? 3'd2 : 3'd3;
        mi_wide  = 10'(acc_reg.mi) * 10'd10 + 10'(dval);

        if (take && (cp_reg < CP_W'(SENTENCE_MAX)))
        begin
            cp_next = cp_reg + 1'b1;
            for (int k = 1; k <= 5; k++)
            begin
                if (cp_reg == CP_W'(k))
                    id_next[(5-k)*8 +: 8] = char_in;
            end

            if (char_in == CH_COMMA)
            begin
                if (fn_reg == FLD_LAT)
                    lat_next = acc_reg;
                else if (fn_reg == FLD_LON)
                    lon_next = acc_reg;
                if (fn_reg != FLD_MAX)
                    fn_next = fn_reg + 4'd1;
                ph_next  = '0;
                dp_next  = '0;
                fs_next  = 1'b1;
                acc_next = '0;
                cnt_next = '0;
            end
            else
            begin
                case (fn_reg)
                    FLD_TIME:
                    begin
                        if (ph_reg == PH_T_DOT)
                            ph_next = (char_in == CH_DOT) ? PH_T_HS : PH_T_DONE;
                        else if ((ph_reg >= PH_T_HH && ph_reg <= PH_T_SS) || ph_reg == PH_T_HS)
                        begin
                            if (is_dig)
                            begin
                                tp_next[part] = 7'(11'(tp_reg[part]) * 11'd10 + 11'(dval));
                                if (dp_reg != '0)
                                begin
                                    dp_next = '0;
                                    ph_next = grp_next;
                                end
                                else
                                    dp_next = 3'd1;
                            end
                            else if (dp_reg != '0)
                            begin
                                // group closed early, the character is seen again
                                dp_next = '0;
                                ph_next = (grp_next == PH_T_DOT && char_in == CH_DOT) ?
                                          PH_T_HS : PH_T_DONE;
                            end
                            else
                                ph_next = PH_T_DONE;
                        end
                    end
                    FLD_STATUS:
                    begin
                        if (fs_reg)
                            ch_next[0] = char_in;
                    end
                    FLD_NS:
                    begin
                        if (fs_reg)
                            ch_next[1] = char_in;
                    end
                    FLD_EW:
                    begin
                        if (fs_reg)
                            ch_next[2] = char_in;
                    end
                    FLD_LAT, FLD_LON:
                    begin
                        case (ph_reg)
                            PH_C_DEG:
                            begin
                                if (is_dig)
                                begin
                                    acc_next.deg = DEG_W'(14'(acc_reg.deg) * 14'd10 + 14'(dval));
                                    if ((dp_reg + 3'd1) >= ndeg)
                                    begin
                                        dp_next = '0;
                                        ph_next = PH_C_MIN;
                                    end
                                    else
                                        dp_next = dp_reg + 3'd1;
                                end
                                else if (dp_reg == '0)
                                    ph_next = PH_C_DONE;
                                else
                                begin
                                    dp_next = '0;
                                    ph_next = (char_in == CH_DOT) ? PH_C_FRAC : PH_C_DONE;
                                end
                            end
                            PH_C_MIN:
                            begin
                                if (is_dig)
                                    acc_next.mi = (mi_wide > 10'd99) ? 7'd99 : mi_wide[6:0];
                                else if (char_in == CH_DOT)
                                    ph_next = PH_C_FRAC;
                                else
                                    ph_next = PH_C_DONE;
                            end
                            PH_C_FRAC:
                            begin
                                if (is_dig)
                                begin
                                    // digits past the configured count are dropped
                                    if ({1'b0, cnt_reg} < 4'(FRACTION_DIGITS))
                                    begin
                                        acc_next.frac = acc_reg.frac + FRAC_W'(28'(dval) *
                                            28'(pow10(3'(FRACTION_DIGITS - 1) - cnt_reg)));
                                        if (cnt_reg < 3'd4)
                                            acc_next.frac_hi = acc_reg.frac_hi + FHI_W'(
                                                28'(dval) * 28'(pow10(3'd3 - cnt_reg)));
                                        cnt_next = cnt_reg + 3'd1;
                                    end
                                end
                                else
                                    ph_next = PH_C_DONE;
                            end
                            default: ;
                        endcase
                    end
                    default: ;
                endcase
                fs_next = 1'b0;
            end
        end
    end

    assign fin = take && last_char;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fn_reg  <= '0;
            cp_reg  <= '0;
            dp_reg  <= '0;
            ph_reg  <= '0;
            fs_reg  <= 1'b1;
            id_reg  <= '0;
            tp_reg  <= '0;
            acc_reg <= '0;
            cnt_reg <= '0;
            lat_reg <= '0;
            lon_reg <= '0;
            ch_reg  <= '0;
        end
        else if (fin)
        begin
            // sentence done, back to the start state
            fn_reg  <= '0;
            cp_reg  <= '0;
            dp_reg  <= '0;
            ph_reg  <= '0;
            fs_reg  <= 1'b1;
            id_reg  <= '0;
            tp_reg  <= '0;
            acc_reg <= '0;
            cnt_reg <= '0;
            lat_reg <= '0;
            lon_reg <= '0;
            ch_reg  <= '0;
        end
        else
        begin
            fn_reg  <= fn_next;
            cp_reg  <= cp_next;
            dp_reg  <= dp_next;
            ph_reg  <= ph_next;
            fs_reg  <= fs_next;
            id_reg  <= id_next;
            tp_reg  <= tp_next;
            acc_reg <= acc_next;
            cnt_reg <= cnt_next;
            lat_reg <= lat_next;
            lon_reg <= lon_next;
            ch_reg  <= ch_next;
        end
    end

    // snapshot; an open coordinate field is closed with its running values
    always_ff @(posedge clk)
    begin
        if (fin)
        begin
            snap_side_reg.id     <= id_next;
            snap_side_reg.utc    <= tp_next;
            snap_side_reg.status <= ch_next[0];
            snap_side_reg.lat_h  <= ch_next[1];
            snap_side_reg.lon_h  <= ch_next[2];
            snap_lat_reg         <= (fn_next == FLD_LAT) ? acc_next : lat_next;
            snap_lon_reg         <= (fn_next == FLD_LON) ? acc_next : lon_next;
        end
    end

    assign snap_side   = snap_side_reg;
    assign lat_deg     = snap_lat_reg.deg;
    assign lat_min     = snap_lat_reg.mi;
    assign lat_frac    = snap_lat_reg.frac;
    assign lat_frac_hi = snap_lat_reg.frac_hi;
    assign lon_deg     = snap_lon_reg.deg;
    assign lon_min     = snap_lon_reg.mi;
    assign lon_frac    = snap_lon_reg.frac;
    assign lon_frac_hi = snap_lon_reg.frac_hi;

endmodule

// ----- rtl/rmc_coord_conv.sv -----
// ----------------------------------------------------------------------------
// rmc_coord_conv: coordinate scaling pipeline
// Four stages turn degrees, minutes and minute fraction into minutes*1e4
// and signed microdegrees, rounding half up via a reciprocal multiply.
// ----------------------------------------------------------------------------
module rmc_coord_conv
    import rmc_pkg::*;
#(
    parameter int FRACTION_DIGITS = FRACTION_DIGITS_DEF
)
(
    input  logic                                    clk,
    input  logic [3:0]                              ce,
    input  logic [DEG_W-1:0]                        deg,
    input  logic [MIN_W-1:0]                        mi,
    input  logic [$clog2(10**FRACTION_DIGITS)-1:0]  frac,
    input  logic [FHI_W-1:0]                        frac_hi,
    input  logic                                    neg,
    output logic [E4_W-1:0]                         e4,
    output logic [MAG_W-1:0]                        mag
);

    localparam int FRAC_W    = $clog2(10**FRACTION_DIGITS);
    // microdegrees of the minutes = floor((min*MUL_MIN + frac*MUL_FRAC + HALF) / DV)
    localparam int MUL_FRAC  = (FRACTION_DIGITS <= 6) ? 10**(6 - FRACTION_DIGITS) : 1;
    localparam int MUL_MIN   = (FRACTION_DIGITS <= 6) ? MICRO : 10**FRACTION_DIGITS;
    localparam int HALF      = (FRACTION_DIGITS <= 6) ? 30 : 300;
    localparam int DV        = (FRACTION_DIGITS <= 6) ? 60 : 600;
    localparam int YMAX      = 99 * MUL_MIN + (10**FRACTION_DIGITS - 1) * MUL_FRAC + HALF;
    localparam int Y_W       = $clog2(YMAX + 1);
    localparam logic [32:0] TWO32 = 33'h1_0000_0000;
    localparam logic [31:0] RECIP = 32'(TWO32 / DV);
    localparam int R_W       = $clog2(RECIP + 1);
    localparam int P_W       = Y_W + R_W;
    localparam int Q_W       = P_W - 32;

    logic [Y_W-1:0]    y1_reg, y2_reg;
    logic [DE6_W-1:0]  de6_1_reg, de6_2_reg, de6_3_reg;
    logic [E4_W-1:0]   e4_1_reg, e4_2_reg, e4_3_reg, e4_4_reg;
    logic              neg1_reg, neg2_reg, neg3_reg;
    logic [P_W-1:0]    prod2_reg;
    logic [Q_W-1:0]    q3_reg;
    logic [MAG_W-1:0]  mag4_reg;

    logic [Q_W-1:0]    q0;
    logic [Y_W-1:0]    rem;
    logic [MAG_W-1:0]  sum4;

    assign q0   = prod2_reg[P_W-1:32];
    // the estimate is at most one low
    assign rem  = y2_reg - Y_W'(Y_W'(q0) * Y_W'(DV));
    assign sum4 = MAG_W'(de6_3_reg) + MAG_W'(q3_reg);

    always_ff @(posedge clk)
    begin
        if (ce[0])
        begin
            y1_reg    <= Y_W'(Y_W'(mi) * Y_W'(MUL_MIN)) + Y_W'(Y_W'(frac) * Y_W'(MUL_FRAC))
                         + Y_W'(HALF);
            de6_1_reg <= DE6_W'(DE6_W'(deg) * DE6_W'(MICRO));
            e4_1_reg  <= E4_W'(E4_W'(mi) * E4_W'(E4_SCALE)) + E4_W'(frac_hi);
            neg1_reg  <= neg;
        end
        if (ce[1])
        begin
            prod2_reg <= P_W'(y1_reg) * P_W'(RECIP);
            y2_reg    <= y1_reg;
            de6_2_reg <= de6_1_reg;
            e4_2_reg  <= e4_1_reg;
            neg2_reg  <= neg1_reg;
        end
        if (ce[2])
        begin
            q3_reg    <= q0 + Q_W'(rem >= Y_W'(DV));
            de6_3_reg <= de6_2_reg;
            e4_3_reg  <= e4_2_reg;
            neg3_reg  <= neg2_reg;
        end
        if (ce[3])
        begin
            mag4_reg  <= neg3_reg ? (MAG_W'(0) - sum4) : sum4;
            e4_4_reg  <= e4_3_reg;
        end
    end

    assign e4  = e4_4_reg;
    assign mag = mag4_reg;

endmodule

// ----- sim/tb_nmea_rmc_sentence_parser_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_nmea_rmc_sentence_parser_core: self-checking bench for the rmc parser
// Streams sentences into the parser one character per item. A short script
// of hand-written sentences comes first. Randomized well-formed, truncated,
// noisy and overlong sentences follow. Both sides of the stream idle at
// random. Each result item is compared field by field with the output of a
// behavioral copy of the parser in the bench, or with hand-written values.
// ----------------------------------------------------------------------------
module tb_nmea_rmc_sentence_parser_core;
    import rmc_pkg::*;

    localparam int HALF_PERIOD  = 5;
    localparam int RESET_CYCLES = 5;
    localparam int CYCLE_LIMIT  = 1000000;
    localparam int DRAIN_CYCLES = 16;
    localparam int RANDOM_CHARS = 1300;
    localparam int RANDOM_FIXES = 36;
    localparam int PRINT_CAP    = 100;
    localparam int FRAC_N       = FRACTION_DIGITS_DEF;
    localparam int SCRIPT_ROWS  = 12;

    // sentence field numbers
    localparam int F_TIME    = 1;
    localparam int F_STATUS  = 2;
    localparam int F_LAT     = 3;
    localparam int F_NS      = 4;
    localparam int F_LON     = 5;
    localparam int F_EW      = 6;
    localparam int FIELD_CAP = 15;

    localparam int LAT_DEG_DIGITS = 2;
    localparam int LON_DEG_DIGITS = 3;

    typedef enum int {T_HH, T_MM, T_SS, T_DOT, T_CS, T_DONE} utc_stage_t;
    typedef enum int {C_DEG, C_MIN, C_FRAC, C_DONE} coord_stage_t;

    // one parsed fix, laid out exactly as m_axis_tdata
    typedef struct packed {
        logic                     pad;
        logic [CHR_W-1:0]         lon_hemi;
        logic [CHR_W-1:0]         lat_hemi;
        logic signed [MAG_W-1:0]  lon_ude;
        logic [E4_W-1:0]          lon_e4;
        logic signed [LATD_W-1:0] lat_ude;
        logic [E4_W-1:0]          lat_e4;
        logic [CHR_W-1:0]         status;
        logic [UTC_W-1:0]         utc_cs;
        logic [UTC_W-1:0]         utc_ss;
        logic [UTC_W-1:0]         utc_mm;
        logic [UTC_W-1:0]         utc_hh;
        logic [ID_W-1:0]          id;
    } fix_t;

    logic               clk = 1'b0;
    logic               rst_n;
    logic               s_axis_tvalid;
    logic               s_axis_tready;
    logic [7:0]         s_axis_tdata;   // char_in
    logic               s_axis_tlast;   // last_char
    logic               m_axis_tvalid;
    logic               m_axis_tready;
    // sentence_id, utc_hour, utc_minute, utc_second, utc_hundredths, status_char,
    // lat_minutes_e4, lat_microdeg, lon_minutes_e4, lon_microdeg, lat_hemisphere,
    // lon_hemisphere, one zero pad bit
    logic [TDATA_W-1:0] m_axis_tdata;

    // parser model state
    int                 fld_idx;
    int                 chr_pos;
    int                 dig_cnt;
    int                 deg_acc;
    int                 min_int;
    int                 min_frac;
    int                 frac_cnt;
    bit                 at_field_start;
    utc_stage_t         t_stage;
    coord_stage_t       c_stage;
    logic [ID_W-1:0]    id_acc;
    logic [UTC_W-1:0]   utc_acc [4];
    logic [E4_W-1:0]    coord_e4 [2];
    longint             coord_mag [2];
    logic [CHR_W-1:0]   status_seen;
    logic [CHR_W-1:0]   ns_seen;
    logic [CHR_W-1:0]   ew_seen;

    fix_t               fix_q [$];
    logic [7:0]         line_q [$];
    string              script_text [SCRIPT_ROWS];
    bit                 script_typed [SCRIPT_ROWS];
    fix_t               script_want [SCRIPT_ROWS];
    bit                 steady_src;
    int                 chars_sent;
    int                 fixes_sent;
    int                 fixes_checked;
    int                 error_count;
    int                 cycle_count;

    nmea_rmc_sentence_parser_core dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #(HALF_PERIOD) clk = ~clk;

    // ------------------------------------------------------------------
    // parser model
    // ------------------------------------------------------------------
    function automatic longint ten_to(input int k);
        longint v;
        v = 1;
        repeat (k) v = v * 10;
        return v;
    endfunction

    function automatic bit is_digit(input logic [7:0] c);
        return c >= CH_ZERO && c <= CH_NINE;
    endfunction

    function automatic int digit_val(input logic [7:0] c);
        return int'(c) - int'(CH_ZERO);
    endfunction

    function automatic void clear_field();
        t_stage  = T_HH;
        c_stage  = C_DEG;
        dig_cnt  = 0;
        deg_acc  = 0;
        min_int  = 0;
        min_frac = 0;
        frac_cnt = 0;
        at_field_start = 1'b1;
    endfunction

    function automatic void clear_parser();
        clear_field();
        fld_idx     = 0;
        chr_pos     = 0;
        id_acc      = '0;
        status_seen = '0;
        ns_seen     = '0;
        ew_seen     = '0;
        for (int i = 0; i < 4; i++)
            utc_acc[i] = '0;
        for (int i = 0; i < 2; i++)
        begin
            coord_e4[i]  = '0;
            coord_mag[i] = 0;
        end
    endfunction

    function automatic void take_time_char(input logic [7:0] c);
        bit redo;
        int idx;
        int v;
        redo = 1'b1;
        // a non-digit after a partial pair closes the pair and is looked at again
        while (redo)
        begin
            redo = 1'b0;
            case (t_stage)
                T_HH, T_MM, T_SS, T_CS:
                begin
                    idx = (t_stage == T_CS) ? 3 : int'(t_stage);
                    if (is_digit(c))
                    begin
                        v = int'(utc_acc[idx]) * 10 + digit_val(c);
                        utc_acc[idx] = v[UTC_W-1:0];
                        dig_cnt++;
                        if (dig_cnt >= 2)
                        begin
                            dig_cnt = 0;
                            t_stage = (t_stage == T_CS) ? T_DONE : utc_stage_t'(t_stage + 1);
                        end
                    end
                    else if (dig_cnt > 0)
                    begin
                        dig_cnt = 0;
                        t_stage = (t_stage == T_CS) ? T_DONE : utc_stage_t'(t_stage + 1);
                        redo    = 1'b1;
                    end
                    else
                        t_stage = T_DONE;
                end
                T_DOT:
                    t_stage = (c == CH_DOT) ? T_CS : T_DONE;
                default: ;
            endcase
        end
    endfunction

    function automatic void take_coord_char(input logic [7:0] c, input int ndeg);
        bit consumed;
        consumed = 1'b0;
        if (c_stage == C_DEG)
        begin
            consumed = 1'b1;
            if (is_digit(c))
            begin
                deg_acc = deg_acc * 10 + digit_val(c);
                dig_cnt++;
                if (dig_cnt >= ndeg)
                begin
                    dig_cnt = 0;
                    c_stage = C_MIN;
                end
            end
            else if (dig_cnt == 0)
                c_stage = C_DONE;
            else
            begin
                // short degree group, the same character goes on to the minutes
                dig_cnt  = 0;
                c_stage  = C_MIN;
                consumed = 1'b0;
            end
        end
        if (!consumed)
        begin
            case (c_stage)
                C_MIN:
                begin
                    if (is_digit(c))
                    begin
                        min_int = min_int * 10 + digit_val(c);
                        if (min_int > 99)
                            min_int = 99;
                    end
                    else if (c == CH_DOT)
                        c_stage = C_FRAC;
                    else
                        c_stage = C_DONE;
                end
                C_FRAC:
                begin
                    if (is_digit(c))
                    begin
                        if (frac_cnt < FRAC_N)
                        begin
                            min_frac = min_frac
                                     + digit_val(c) * int'(ten_to(FRAC_N - 1 - frac_cnt));
                            frac_cnt++;
                        end
                    end
                    else
                        c_stage = C_DONE;
                end
                default: ;
            endcase
        end
    endfunction

    function automatic void latch_coord(input int slot);
        longint scale;
        longint num;
        longint den;
        longint e4;
        scale = ten_to(FRAC_N);
        num   = longint'(min_int) * scale + min_frac;
        den   = 60 * scale;
        coord_mag[slot] = longint'(deg_acc) * MICRO + (num * MICRO + den / 2) / den;
        e4 = longint'(min_int) * E4_SCALE + min_frac / ten_to(FRAC_N - 4);
        coord_e4[slot] = e4[E4_W-1:0];
    endfunction

    function automatic void close_field();
        if (fld_idx == F_LAT)
            latch_coord(0);
        else if (fld_idx == F_LON)
            latch_coord(1);
    endfunction

    task automatic parse_char(input logic [7:0] c, input logic l,
                              output bit got, output fix_t fix);
        longint lat;
        longint lon;
        got = 1'b0;
        fix = '0;
        if (chr_pos < SENTENCE_MAX_DEF)
        begin
            if (chr_pos >= 1 && chr_pos <= 5)
                id_acc = id_acc | ({32'd0, c} << ((5 - chr_pos) * 8));
            chr_pos++;
            if (c == CH_COMMA)
            begin
                close_field();
                if (fld_idx < FIELD_CAP)
                    fld_idx++;
                clear_field();
            end
            else
            begin
                case (fld_idx)
                    F_TIME:   take_time_char(c);
                    F_STATUS: if (at_field_start) status_seen = c;
                    F_LAT:    take_coord_char(c, LAT_DEG_DIGITS);
                    F_NS:     if (at_field_start) ns_seen = c;
                    F_LON:    take_coord_char(c, LON_DEG_DIGITS);
                    F_EW:     if (at_field_start) ew_seen = c;
                    default: ;
                endcase
                at_field_start = 1'b0;
            end
        end
        if (l)
        begin
            close_field();
            lat = (ns_seen == CH_SOUTH) ? -coord_mag[0] : coord_mag[0];
            lon = (ew_seen == CH_WEST) ? -coord_mag[1] : coord_mag[1];
            fix.id       = id_acc;
            fix.utc_hh   = utc_acc[0];
            fix.utc_mm   = utc_acc[1];
            fix.utc_ss   = utc_acc[2];
            fix.utc_cs   = utc_acc[3];
            fix.status   = status_seen;
            fix.lat_e4   = coord_e4[0];
            fix.lat_ude  = lat[LATD_W-1:0];
            fix.lon_e4   = coord_e4[1];
            fix.lon_ude  = lon[MAG_W-1:0];
            fix.lat_hemi = ns_seen;
            fix.lon_hemi = ew_seen;
            got = 1'b1;
            clear_parser();
        end
    endtask

    // ------------------------------------------------------------------
    // sentence builders, all append to line_q (build_random_line clears it first)
    // ------------------------------------------------------------------
    function automatic void put_text(input string s);
        for (int i = 0; i < s.len(); i++)
            line_q.push_back(s[i]);
    endfunction

    function automatic void put_digits(input int n);
        repeat (n) line_q.push_back(8'(CH_ZERO + $urandom_range(0, 9)));
    endfunction

    function automatic void put_choice(input string pair);
        int r;
        r = $urandom_range(0, 9);
        if (r < 9)
            line_q.push_back(pair[r % 2]);
        else
            line_q.push_back(8'($urandom_range(0, 255)));
    endfunction

    function automatic void put_coord(input int ndeg);
        put_digits(($urandom_range(0, 7) != 0) ? ndeg : $urandom_range(0, ndeg + 1));
        put_digits(($urandom_range(0, 7) != 0) ? 2 : $urandom_range(0, 4));
        if ($urandom_range(0, 7) != 0)
        begin
            line_q.push_back(CH_DOT);
            put_digits($urandom_range(0, 8));
        end
    endfunction

    function automatic void build_fix_sentence();
        int start;
        put_text("$");
        if ($urandom_range(0, 3) != 0)
            put_text("GPRMC");
        else
            repeat (5) line_q.push_back(8'($urandom_range(33, 126)));
        for (int f = F_TIME; f <= F_EW; f++)
        begin
            line_q.push_back(CH_COMMA);
            start = line_q.size();
            if ($urandom_range(0, 9) != 0)
            begin
                case (f)
                    F_TIME:
                    begin
                        put_digits(($urandom_range(0, 4) != 0) ? 6 : $urandom_range(0, 8));
                        if ($urandom_range(0, 3) != 0)
                        begin
                            line_q.push_back(CH_DOT);
                            put_digits($urandom_range(0, 3));
                        end
                    end
                    F_STATUS: put_choice("AV");
                    F_LAT:    put_coord(LAT_DEG_DIGITS);
                    F_NS:     put_choice("NS");
                    F_LON:    put_coord(LON_DEG_DIGITS);
                    default:  put_choice("EW");
                endcase
                // now and then one stray byte somewhere in the field
                if ($urandom_range(0, 7) == 0 && line_q.size() > start)
                    line_q[$urandom_range(start, line_q.size() - 1)] = 8'($urandom_range(0, 255));
            end
        end
        repeat ($urandom_range(0, 4))
        begin
            line_q.push_back(CH_COMMA);
            put_digits($urandom_range(0, 4));
        end
    endfunction

    function automatic void build_noise(input int n);
        repeat (n)
        begin
            case ($urandom_range(0, 9))
                0, 1, 2: line_q.push_back(CH_COMMA);
                3, 4, 5: line_q.push_back(8'(CH_ZERO + $urandom_range(0, 9)));
                6:       line_q.push_back(CH_DOT);
                default: line_q.push_back(8'($urandom_range(0, 255)));
            endcase
        end
    endfunction

    function automatic void build_random_line();
        int r;
        int keep;
        line_q.delete();
        r = $urandom_range(0, 99);
        if (r < 70)
            build_fix_sentence();
        else if (r < 82)
        begin
            build_fix_sentence();
            keep = $urandom_range(1, line_q.size());
            while (line_q.size() > keep)
                void'(line_q.pop_back());
        end
        else if (r < 95)
            build_noise($urandom_range(1, 24));
        else
        begin
            // may run past the sentence length limit
            build_fix_sentence();
            build_noise($urandom_range(90, 150));
        end
    endfunction

    // ------------------------------------------------------------------
    // source side
    // ------------------------------------------------------------------
    function automatic int pick_gap();
        int r;
        if (steady_src)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 65)
            return 0;
        else if (r < 92)
            return $urandom_range(1, 3);
        else
            return $urandom_range(6, 30);
    endfunction

    // called at a falling edge, returns at the falling edge after the handshake
    task automatic send_char(input logic [7:0] c, input logic l,
                             output bit got, output fix_t fix);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            s_axis_tvalid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tdata  = c;
        s_axis_tlast  = l;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        parse_char(c, l, got, fix);
        chars_sent++;
        @(negedge clk);
    endtask

    task automatic send_line(input bit typed, input fix_t want);
        bit   got;
        fix_t fix;
        got = 1'b0;
        steady_src = ($urandom_range(0, 3) == 0);
        foreach (line_q[i])
            send_char(line_q[i], i == line_q.size() - 1, got, fix);
        if (got)
        begin
            fix_q.push_back(typed ? want : fix);
            fixes_sent++;
        end
    endtask

    // ------------------------------------------------------------------
    // sink side
    // ------------------------------------------------------------------
    initial
    begin : sink_pacing
        int hold;
        hold = 0;
        m_axis_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold > 0)
                hold--;
            else if (m_axis_tready)
            begin
                m_axis_tready = 1'b0;
                hold = ($urandom_range(0, 3) != 0) ? $urandom_range(0, 2) : $urandom_range(5, 40);
            end
            else
            begin
                m_axis_tready = 1'b1;
                hold = ($urandom_range(0, 7) != 0) ? $urandom_range(0, 20)
                                                   : $urandom_range(40, 150);
            end
        end
    end

    task automatic report_error(input string msg);
        if (error_count < PRINT_CAP)
            $display("%0t ns: fix %0d: %s", $time, fixes_checked, msg);
        error_count++;
    endtask

    task automatic compare_field(input string name, input longint seen, input longint want);
        if (seen != want)
            report_error($sformatf("%s is %0d, expected %0d", name, seen, want));
    endtask

    always @(posedge clk)
    begin : check_fix
        fix_t seen;
        fix_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            seen = fix_t'(m_axis_tdata);
            if (fix_q.size() == 0)
                report_error("result item with no sentence pending");
            else
            begin
                want = fix_q.pop_front();
                compare_field("sentence_id", seen.id, want.id);
                compare_field("utc_hour", seen.utc_hh, want.utc_hh);
                compare_field("utc_minute", seen.utc_mm, want.utc_mm);
                compare_field("utc_second", seen.utc_ss, want.utc_ss);
                compare_field("utc_hundredths", seen.utc_cs, want.utc_cs);
                compare_field("status_char", seen.status, want.status);
                compare_field("lat_minutes_e4", seen.lat_e4, want.lat_e4);
                compare_field("lat_microdeg", seen.lat_ude, want.lat_ude);
                compare_field("lon_minutes_e4", seen.lon_e4, want.lon_e4);
                compare_field("lon_microdeg", seen.lon_ude, want.lon_ude);
                compare_field("lat_hemisphere", seen.lat_hemi, want.lat_hemi);
                compare_field("lon_hemisphere", seen.lon_hemi, want.lon_hemi);
            end
            fixes_checked++;
        end
    end

    initial
    begin : watchdog
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("timeout after %0d cycles, %0d results outstanding",
                 cycle_count, fix_q.size());
        $display("** nmea_rmc_sentence_parser_core: FAILED **");
        $finish;
    end

    // ------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------
    initial
    begin : stimulus
        int char_base;
        int fix_base;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tlast  = 1'b0;
        rst_n         = 1'b0;
        steady_src    = 1'b0;
        chars_sent    = 0;
        fixes_sent    = 0;
        fixes_checked = 0;
        error_count   = 0;
        clear_parser();

        // '~' in a script row stands for a nul character
        script_text = '{
            "$",
            "$GPRMC",
            "$,,,,,,",
            "$GPRMC,235959.99,A,9959.99999,S,17959.99999,W",
            "$GNRMC,000000.00,V,0000.0000,N,00000.0000,E,,,",
            "$GPRMC,1234,A,12345.6789012,N,99999.99999999,E",
            "$GPRMC,12x456.7,A,48-07.038,N,011 31.0e2,W",
            "$GPRMC,1.5,A,4.5,S,9.,E,1,2,3",
            ",,,,,,,,,,,,,,,,,,,,7",
            "~$~$$,093000.5,~,-12,S,+012,W",
            "$GPRMC,123519.00,A,4807.0381,N,",
            "$GPRMC,123519,A,4807.038,N,01131.000,E,022.4,084.4,230394,003.1,W*6A"
        };
        // overlong: the longitude runs past the sentence length limit
        repeat (110) script_text[10] = {script_text[10], "9"};
        script_text[10] = {script_text[10], ",01131.000,E"};

        foreach (script_want[i])
        begin
            script_want[i]  = '0;
            script_typed[i] = 1'b0;
        end
        // lone start character, bare identifier, all fields empty
        script_typed[0] = 1'b1;
        script_typed[1] = 1'b1;
        script_want[1].id = 40'h4750524D43;
        script_typed[2] = 1'b1;
        script_want[2].id = 40'h2C2C2C2C2C;

        repeat (RESET_CYCLES) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        for (int r = 0; r < SCRIPT_ROWS; r++)
        begin
            line_q.delete();
            for (int i = 0; i < script_text[r].len(); i++)
                line_q.push_back((script_text[r][i] == "~") ? 8'h00 : script_text[r][i]);
            send_line(script_typed[r], script_want[r]);
        end

        char_base = chars_sent;
        fix_base  = fixes_sent;
        while (chars_sent - char_base < RANDOM_CHARS || fixes_sent - fix_base < RANDOM_FIXES)
        begin
            build_random_line();
            send_line(1'b0, '0);
        end
        s_axis_tvalid = 1'b0;
        s_axis_tlast  = 1'b0;

        while (fix_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (error_count == 0)
            $display("** nmea_rmc_sentence_parser_core: PASSED **");
        else
            $display("** nmea_rmc_sentence_parser_core: FAILED **");
        $finish;
    end

endmodule

// ----- filelist.f -----
rtl/rmc_pkg.sv
rtl/rmc_char_parser.sv
rtl/rmc_coord_conv.sv
rtl/nmea_rmc_sentence_parser_core.sv
sim/tb_nmea_rmc_sentence_parser_core.sv
